/* rtl/core/ede_pkg.sv */
`default_nettype none
package ede_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int CHAR_W      = 8;
  localparam int DIST_W      = 7;

  typedef enum logic [1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_PROC_B   = 2'd1,
    CMD_FINISH   = 2'd2
  } ede_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_FIN
  } ede_state_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [CHAR_W-1:0] char_value;
  } ede_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } ede_out_t;

  typedef struct packed {
    logic a_we;
    logic row_we;
  } ede_wr_en_t;

endpackage
`default_nettype wire

/* rtl/core/edit_distance_engine_unit.sv */
`default_nettype none
// levenshtein edit distance between two byte strings of up to MAX_LEN chars
// a request is taken at a clock edge with start high and busy low
// commands: append a char to string a, process a char of string b, finish
// append a: busy stays low; ignored once string b has begun
// process b: one stored a char per cycle while busy, set by the single cell
//   unit stepping along the row memory; busy stays low when a is empty or b is full
// finish: the block goes busy, then the result sits on out_res in the next cycle
// out_strobe is high for exactly one cycle with the result on out_res;
//   the receiver cannot stall, so it must take it in that cycle
// chars beyond MAX_LEN in either string are dropped and too_long is set
// finish clears lengths and flag for the next pair of strings
// reset clears the sequencer and counters only; the char and row memories
//   need no clearing since only entries already loaded are ever used
module edit_distance_engine_unit
  import ede_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire ede_in_t  in_req,
  output logic          busy,
  output logic          out_strobe,
  output ede_out_t      out_res
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  ede_wr_en_t        wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CHAR_W-1:0] a_wdata;
  logic [CW-1:0]     row_wdata;
  logic [AW-1:0]     rd_addr;
  logic [CHAR_W-1:0] a_q;
  logic [CW-1:0]     row_q;

  ede_store #(.MAX_LEN(MAX_LEN), .AW(AW), .CW(CW)) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .a_wdata   (a_wdata),
    .row_wdata (row_wdata),
    .rd_addr   (rd_addr),
    .a_q       (a_q),
    .row_q     (row_q)
  );

  ede_seq #(.MAX_LEN(MAX_LEN), .AW(AW), .CW(CW)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_req     (in_req),
    .busy       (busy),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .a_wdata    (a_wdata),
    .row_wdata  (row_wdata),
    .rd_addr    (rd_addr),
    .a_q        (a_q),
    .row_q      (row_q),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a finish in progress");

  a_finish_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req.command == CMD_FINISH)) |=> busy)
    else $error("finish request did not make the block busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_no_write_on_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(start && !busy && (in_req.command == CMD_FINISH)))
      |-> !(wr_en.a_we || wr_en.row_we))
    else $error("store written while reporting a result");

endmodule
`default_nettype wire

/* rtl/core/ede_cell.sv */
`default_nettype none
module ede_cell
  import ede_pkg::*;
#(
  parameter int CW = 7
) (
  input  wire logic [CW-1:0]     up,
  input  wire logic [CW-1:0]     left,
  input  wire logic [CW-1:0]     diag,
  input  wire logic [CHAR_W-1:0] a_char,
  input  wire logic [CHAR_W-1:0] b_char,
  output logic      [CW-1:0]     cell_cost
);

  logic [CW:0] up_inc;
  logic [CW:0] left_inc;
  logic [CW:0] diag_cost;
  logic [CW:0] min_ul;
  logic [CW:0] min_all;

  always_comb begin
    up_inc    = {1'b0, up} + (CW+1)'(1);
    left_inc  = {1'b0, left} + (CW+1)'(1);
    diag_cost = {1'b0, diag} + (CW+1)'(a_char != b_char);
    min_ul    = (up_inc < left_inc) ? up_inc : left_inc;
    min_all   = (min_ul < diag_cost) ? min_ul : diag_cost;
    cell_cost = min_all[CW-1:0];
  end

endmodule
`default_nettype wire

/* rtl/core/ede_store.sv */
`default_nettype none
module ede_store
  import ede_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int AW      = 6,
  parameter int CW      = 7
) (
  input  wire logic                  clk,
  input  wire ede_wr_en_t            wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [CHAR_W-1:0]     a_wdata,
  input  wire logic [CW-1:0]         row_wdata,
  input  wire logic [AW-1:0]         rd_addr,
  output logic      [CHAR_W-1:0]     a_q,
  output logic      [CW-1:0]         row_q
);

  logic [CHAR_W-1:0] a_mem   [MAX_LEN];
  logic [CW-1:0]     row_mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (wr_en.a_we) begin
      a_mem[wr_addr] <= a_wdata;
    end
    if (wr_en.row_we) begin
      row_mem[wr_addr] <= row_wdata;
    end
    a_q   <= a_mem[rd_addr];
    row_q <= row_mem[rd_addr];
  end

endmodule
`default_nettype wire

/* rtl/core/ede_seq.sv */
`default_nettype none
module ede_seq
  import ede_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int AW      = 6,
  parameter int CW      = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire ede_in_t           in_req,
  output logic                   busy,
  output ede_wr_en_t             wr_en,
  output logic      [AW-1:0]     wr_addr,
  output logic      [CHAR_W-1:0] a_wdata,
  output logic      [CW-1:0]     row_wdata,
  output logic      [AW-1:0]     rd_addr,
  input  wire logic [CHAR_W-1:0] a_q,
  input  wire logic [CW-1:0]     row_q,
  output logic                   out_strobe,
  output ede_out_t               out_res
);

  ede_state_t        state_r, state_nxt;
  logic [CW-1:0]     a_len_r, a_len_nxt;
  logic [CW-1:0]     b_cnt_r, b_cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [CW-1:0]     diag_r, diag_nxt;
  logic [CW-1:0]     left_r, left_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  ede_out_t          out_res_r, out_res_nxt;

  logic              accept;
  ede_cmd_t          cmd;
  logic [CW-1:0]     cell_cost;
  logic              last_cell;
  logic [CW-1:0]     a_last;
  logic [CW-1:0]     dist_val;
  logic [CW+DIST_W-1:0] dist_ext;

  ede_cell #(.CW(CW)) u_cell (
    .up        (row_q),
    .left      (left_r),
    .diag      (diag_r),
    .a_char    (a_q),
    .b_char    (ch_r),
    .cell_cost (cell_cost)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cmd       = ede_cmd_t'(in_req.command);
  assign last_cell = ((CW'(idx_r) + CW'(1)) == a_len_r);
  assign a_last    = a_len_r - CW'(1);
  assign dist_val  = (a_len_r == '0) ? b_cnt_r : row_q;
  assign dist_ext  = {{DIST_W{1'b0}}, dist_val};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PROC_B: begin
              if ((b_cnt_r != CW'(MAX_LEN)) && (a_len_r != '0)) begin
                state_nxt = ST_ROW;
              end
            end
            CMD_FINISH: state_nxt = ST_FIN;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ROW: begin
        if (last_cell) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en          = '0;
    wr_addr        = a_len_r[AW-1:0];
    a_wdata        = in_req.char_value;
    row_wdata      = a_len_r + CW'(1);
    rd_addr        = '0;
    a_len_nxt      = a_len_r;
    b_cnt_nxt      = b_cnt_r;
    ovf_nxt        = ovf_r;
    idx_nxt        = idx_r;
    ch_nxt         = ch_r;
    diag_nxt       = diag_r;
    left_nxt       = left_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_APPEND_A: begin
              if (b_cnt_r == '0) begin
                if (a_len_r == CW'(MAX_LEN)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  wr_en.a_we   = 1'b1;
                  wr_en.row_we = 1'b1;
                  a_len_nxt    = a_len_r + CW'(1);
                end
              end
            end
            CMD_PROC_B: begin
              if (b_cnt_r == CW'(MAX_LEN)) begin
                ovf_nxt = 1'b1;
              end else if (a_len_r == '0) begin
                b_cnt_nxt = b_cnt_r + CW'(1);
              end else begin
                ch_nxt   = in_req.char_value;
                diag_nxt = b_cnt_r;
                left_nxt = b_cnt_r + CW'(1);
                idx_nxt  = '0;
                rd_addr  = '0;
              end
            end
            CMD_FINISH: rd_addr = a_last[AW-1:0];
            default: ;
          endcase
        end
      end
      ST_ROW: begin
        wr_en.row_we = 1'b1;
        wr_addr      = idx_r;
        row_wdata    = cell_cost;
        diag_nxt     = row_q;
        left_nxt     = cell_cost;
        idx_nxt      = idx_r + AW'(1);
        rd_addr      = idx_r + AW'(1);
        if (last_cell) begin
          b_cnt_nxt = b_cnt_r + CW'(1);
        end
      end
      ST_FIN: begin
        out_strobe_nxt       = 1'b1;
        out_res_nxt.distance = dist_ext[DIST_W-1:0];
        out_res_nxt.too_long = ovf_r;
        a_len_nxt            = '0;
        b_cnt_nxt            = '0;
        ovf_nxt              = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      a_len_r      <= '0;
      b_cnt_r      <= '0;
      ovf_r        <= 1'b0;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      a_len_r      <= a_len_nxt;
      b_cnt_r      <= b_cnt_nxt;
      ovf_r        <= ovf_nxt;
      idx_r        <= idx_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r      <= ch_nxt;
    diag_r    <= diag_nxt;
    left_r    <= left_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule
`default_nettype wire
